>>> design/wscm_pkg.sv
`default_nettype none
package wscm_pkg;

	localparam int DEPTH_DEFAULT = 16;

	// Arithmetic widths cover windows up to 64 entries
	localparam int SMP_W = 32;
	localparam int SUM_W = 40;
	localparam int SQ_W = 72;
	localparam int CMP_W = 88;
	localparam int MED_W = 34;
	localparam int DIF_W = 36;

	// Serial multiplier: MUL_AW x MUL_BW, one byte of b per cycle
	localparam int MUL_AW = 72;
	localparam int MUL_BW = 40;
	localparam int MUL_PW = MUL_AW + MUL_BW;
	localparam int MUL_STEPS = MUL_BW / 8;

	// Serial restoring divider
	localparam int DIV_W = 48;
	localparam int DVS_W = 8;

	localparam int MEAN_W = 40;
	localparam int CNT_OUT_W = 5;
	localparam int TDATA_OUT_W = 88;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SUM_RD,
		ST_SUM_GO,
		ST_SUM_WT,
		ST_NQ_GO,
		ST_NQ_WT,
		ST_SS_GO,
		ST_SS_WT,
		ST_MED_ORD,
		ST_MED_OLD,
		ST_MED_IRD,
		ST_MED_CMP,
		ST_MED_EVAL,
		ST_M2,
		ST_KEEP_RD,
		ST_KEEP_GO,
		ST_KEEP_WT,
		ST_KEEP_GO2,
		ST_KEEP_WT2,
		ST_DIV_GO,
		ST_DIV_WT,
		ST_DONE
	} wscm_state_t;

endpackage
`default_nettype wire

>>> design/windowed_sigma_clipped_mean_core.sv
// Windowed sigma-clipped mean.
// Input stream s_*: one beat carries a signed 32-bit sample that is pushed into a
// ring window of WINDOW_DEPTH entries (the oldest entry is overwritten once full).
// Output stream m_*: one beat per input beat with the mean of the samples that lie
// within one sample standard deviation of the window median (Q8, rounded to
// nearest, ties away from zero), the window count, the kept count and the sample.
// The window sits in a synchronous RAM with one write and one read port; a
// sequencer walks it several times per sample. With n held samples, the time
// per item from accept to the next s_tready is set by the n*n rank-count median
// search over the RAM read port, the serial byte multiplier (MUL_STEPS = 5) and
// the serial divider (DIV_W = 48). s_tready is high only while idle.
// A finished result waits in the output register; the next sample may be taken
// and processed meanwhile, but its result holds until m_tready drains the first.
// Reset clears the write pointer and fill count; the window RAM itself is not
// cleared, entries beyond the fill count are never read.
`default_nettype none
module windowed_sigma_clipped_mean_core #(
	parameter int WINDOW_DEPTH = wscm_pkg::DEPTH_DEFAULT
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [wscm_pkg::SMP_W-1:0]         s_tdata,  // [31:0] sample
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [39:0] filtered_mean_q8, [44:40] window_count, [49:45] kept_count,
	// [81:50] newest_sample, [87:82] zero
	output logic      [wscm_pkg::TDATA_OUT_W-1:0]   m_tdata
);
	import wscm_pkg::*;

	localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	wscm_state_t state_q, state_d;

	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             idx_q, jdx_q, lt_q, le_q, kept_q;
	logic [SMP_W-1:0]          newest_q;
	logic signed [SUM_W-1:0]   sum_q, ksum_q;
	logic [SQ_W-1:0]           sq_q;
	logic [CMP_W-1:0]          nq_q, var4_q;
	logic signed [SMP_W-1:0]   cand_q, lo_q, hi_q, v_q;
	logic signed [MED_W-1:0]   m2_q;
	logic [2*CW-1:0]           nn1_q;
	logic [MUL_AW-1:0]         d2_q;
	logic                      m_tvalid_q;
	logic [TDATA_OUT_W-1:0]    m_tdata_q;

	logic                      accept, load;
	logic [SMP_W-1:0]          rdata;
	logic signed [SMP_W-1:0]   rd_s;
	logic [AW-1:0]             raddr;
	logic [CW-1:0]             idx_inc, jdx_inc, k1, k2, kdiv;
	logic [SMP_W-1:0]          rd_mag;
	logic [SUM_W-1:0]          sum_mag, ksum_mag;
	logic signed [DIF_W-1:0]   dif;
	logic [DIF_W-1:0]          dif_mag;
	logic                      mul_start, mul_done, div_start, div_done;
	logic [MUL_AW-1:0]         mul_a;
	logic [MUL_BW-1:0]         mul_b;
	logic [MUL_PW-1:0]         mul_prod;
	logic [DIV_W-1:0]          div_dvd, div_quo, mean_full;
	logic [DVS_W-1:0]          div_dvs;
	logic [7:0]                wc8, kc8;

	wscm_window #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_window (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (s_tdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	wscm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wscm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign rd_s     = $signed(rdata);
	assign rd_mag   = rd_s[SMP_W-1] ? SMP_W'(-rd_s) : rdata;
	assign sum_mag  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign ksum_mag = ksum_q[SUM_W-1] ? SUM_W'(-ksum_q) : SUM_W'(ksum_q);
	assign dif      = (DIF_W'(rd_s) <<< 1) - DIF_W'(m2_q);
	assign dif_mag  = dif[DIF_W-1] ? DIF_W'(-dif) : DIF_W'(dif);
	assign idx_inc  = idx_q + CW'(1);
	assign jdx_inc  = jdx_q + CW'(1);
	assign k1       = (fill_q - CW'(1)) >> 1;
	assign k2       = fill_q >> 1;
	assign kdiv     = (kept_q == '0) ? CW'(1) : kept_q;
	assign div_dvd  = DIV_W'({ksum_mag, 9'b0}) + DIV_W'(kdiv);
	assign div_dvs  = DVS_W'({kdiv, 1'b0});
	assign mean_full = ksum_q[SUM_W-1] ? DIV_W'(-div_quo) : div_quo;
	assign wc8      = 8'(fill_q);
	assign kc8      = 8'(kept_q);
	assign accept   = s_tvalid && s_tready;
	assign load     = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (s_tvalid) state_d = ST_SUM_RD;
			ST_SUM_RD:    state_d = ST_SUM_GO;
			ST_SUM_GO:    state_d = ST_SUM_WT;
			ST_SUM_WT:    if (mul_done) state_d = (idx_inc == fill_q) ? ST_NQ_GO : ST_SUM_RD;
			ST_NQ_GO:     state_d = ST_NQ_WT;
			ST_NQ_WT:     if (mul_done) state_d = ST_SS_GO;
			ST_SS_GO:     state_d = ST_SS_WT;
			ST_SS_WT:     if (mul_done) state_d = ST_MED_ORD;
			ST_MED_ORD:   state_d = ST_MED_OLD;
			ST_MED_OLD:   state_d = ST_MED_IRD;
			ST_MED_IRD:   state_d = ST_MED_CMP;
			ST_MED_CMP:   state_d = (jdx_inc == fill_q) ? ST_MED_EVAL : ST_MED_IRD;
			ST_MED_EVAL:  state_d = (idx_inc == fill_q) ? ST_M2 : ST_MED_ORD;
			ST_M2:        state_d = ST_KEEP_RD;
			ST_KEEP_RD:   state_d = ST_KEEP_GO;
			ST_KEEP_GO:   state_d = ST_KEEP_WT;
			ST_KEEP_WT:   if (mul_done) state_d = ST_KEEP_GO2;
			ST_KEEP_GO2:  state_d = ST_KEEP_WT2;
			ST_KEEP_WT2:  if (mul_done) state_d = (idx_inc == fill_q) ? ST_DIV_GO : ST_KEEP_RD;
			ST_DIV_GO:    state_d = ST_DIV_WT;
			ST_DIV_WT:    if (div_done) state_d = ST_DONE;
			ST_DONE:      if (load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready  = (state_q == ST_IDLE);
		raddr     = (state_q == ST_MED_IRD) ? jdx_q[AW-1:0] : idx_q[AW-1:0];
		mul_start = 1'b0;
		div_start = (state_q == ST_DIV_GO);
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_SUM_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(rd_mag);
				mul_b     = MUL_BW'(rd_mag);
			end
			ST_NQ_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(sq_q);
				mul_b     = MUL_BW'(fill_q);
			end
			ST_SS_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(sum_mag);
				mul_b     = MUL_BW'(sum_mag);
			end
			ST_KEEP_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_AW'(dif_mag);
				mul_b     = MUL_BW'(dif_mag);
			end
			ST_KEEP_GO2: begin
				mul_start = 1'b1;
				mul_a     = d2_q;
				mul_b     = MUL_BW'(nn1_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				wp_q <= (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + AW'(1);
				if (fill_q != CW'(WINDOW_DEPTH)) begin
					fill_q <= fill_q + CW'(1);
				end
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				newest_q <= s_tdata;
				idx_q    <= '0;
				sum_q    <= '0;
				sq_q     <= '0;
			end
			ST_SUM_GO: sum_q <= sum_q + SUM_W'(rd_s);
			ST_SUM_WT: begin
				if (mul_done) begin
					sq_q  <= sq_q + mul_prod[SQ_W-1:0];
					idx_q <= idx_inc;
				end
			end
			ST_NQ_WT: if (mul_done) nq_q <= mul_prod[CMP_W-1:0];
			ST_SS_WT: begin
				if (mul_done) begin
					var4_q <= (nq_q - mul_prod[CMP_W-1:0]) << 2;
					idx_q  <= '0;
				end
			end
			ST_MED_OLD: begin
				cand_q <= rd_s;
				jdx_q  <= '0;
				lt_q   <= '0;
				le_q   <= '0;
			end
			ST_MED_CMP: begin
				if (rd_s < cand_q) lt_q <= lt_q + CW'(1);
				if (rd_s <= cand_q) le_q <= le_q + CW'(1);
				jdx_q <= jdx_inc;
			end
			ST_MED_EVAL: begin
				// candidate occupies sorted ranks lt .. le-1
				if (lt_q <= k1 && k1 < le_q) lo_q <= cand_q;
				if (lt_q <= k2 && k2 < le_q) hi_q <= cand_q;
				idx_q <= idx_inc;
			end
			ST_M2: begin
				m2_q   <= MED_W'(lo_q) + MED_W'(hi_q);
				nn1_q  <= (2*CW)'(fill_q) * (2*CW)'(fill_q - CW'(1));
				idx_q  <= '0;
				ksum_q <= '0;
				kept_q <= '0;
			end
			ST_KEEP_GO: v_q <= rd_s;
			ST_KEEP_WT: if (mul_done) d2_q <= mul_prod[MUL_AW-1:0];
			ST_KEEP_WT2: begin
				if (mul_done) begin
					if (mul_prod[CMP_W-1:0] <= var4_q) begin
						ksum_q <= ksum_q + SUM_W'(v_q);
						kept_q <= kept_q + CW'(1);
					end
					idx_q <= idx_inc;
				end
			end
			default: begin
			end
		endcase
		if (load) begin
			m_tdata_q <= TDATA_OUT_W'({newest_q, kc8[CNT_OUT_W-1:0], wc8[CNT_OUT_W-1:0],
				mean_full[MEAN_W-1:0]});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire

>>> design/wscm_window.sv
`default_nettype none
module wscm_window #(
	parameter int DEPTH = wscm_pkg::DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic [wscm_pkg::SMP_W-1:0]   wdata,
	input  wire logic [AW-1:0]                raddr,
	output logic      [wscm_pkg::SMP_W-1:0]   rdata
);
	import wscm_pkg::*;

	logic [SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> design/wscm_mul.sv
`default_nettype none
module wscm_mul (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wscm_pkg::MUL_AW-1:0]   a,
	input  wire logic [wscm_pkg::MUL_BW-1:0]   b,
	output logic                               done,
	output logic      [wscm_pkg::MUL_PW-1:0]   prod
);
	import wscm_pkg::*;

	localparam int CNT_W = $clog2(MUL_STEPS + 1);

	logic [MUL_AW-1:0] a_q;
	logic [MUL_BW-1:0] b_q;
	logic [MUL_PW-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	// msb byte first: acc = acc * 256 + a * byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MUL_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << 8) + MUL_PW'(a_q * b_q[MUL_BW-1 -: 8]);
			b_q   <= b_q << 8;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

>>> design/wscm_div.sv
`default_nettype none
module wscm_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [wscm_pkg::DIV_W-1:0]    dividend,
	input  wire logic [wscm_pkg::DVS_W-1:0]    divisor,
	output logic                               done,
	output logic      [wscm_pkg::DIV_W-1:0]    quotient
);
	import wscm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// quotient bits shift into the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire
